### rtl/stet_pkg.sv
// Shared types, codes and defaults for the sorted top entries table.
`default_nettype none

package stet_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int NAME_CHARS_DEF = 8;

    localparam int MODE_W  = 3;
    localparam int NAME_W  = 64;
    localparam int SCORE_W = 32;
    localparam int TAG_W   = 32;
    localparam int POS_W   = 8;

    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_MATCH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;

    // name, score, tag, position
    localparam int IN_DATA_W  = 136;
    // ok, read_name, read_score, is_empty, is_full, last_score
    localparam int OUT_DATA_W = 136;

    typedef struct packed {
        logic load;
        logic find;
        logic apply;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/stet_ctrl.sv
// Sequencing state machine: load, compare, update, hand out the result beat.
`default_nettype none

module stet_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output stet_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIND  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FIND;
                end
            end
            S_FIND:  n_state = S_APPLY;
            S_APPLY: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.find  = (r_state == S_FIND);
    assign o_cmd.apply = (r_state == S_APPLY);

    a_load_to_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.find)
        else $error("load not followed by compare");
    a_find_to_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.find |=> o_cmd.apply)
        else $error("compare not followed by update");
    a_apply_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> o_out_valid)
        else $error("update not followed by result beat");

endmodule

`default_nettype wire

### rtl/stet_datapath.sv
// Entry cells, compare vectors, shift/insert update and result registers.
`default_nettype none

module stet_datapath #(
    parameter int ENTRIES    = stet_pkg::ENTRIES_DEF,
    parameter int NAME_CHARS = stet_pkg::NAME_CHARS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  stet_pkg::t_cmd                    i_cmd,
    input  wire  [stet_pkg::MODE_W-1:0]       i_mode,
    input  wire  [stet_pkg::NAME_W-1:0]       i_name_key,
    input  wire  [stet_pkg::SCORE_W-1:0]      i_score,
    input  wire  [stet_pkg::TAG_W-1:0]        i_tag,
    input  wire  [stet_pkg::POS_W-1:0]        i_position,
    output logic                              o_ok,
    output logic [stet_pkg::NAME_W-1:0]       o_read_name,
    output logic [stet_pkg::SCORE_W-1:0]      o_read_score,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    output logic [stet_pkg::SCORE_W-1:0]      o_last_score
);

    localparam int NW = stet_pkg::NAME_W;
    localparam int SW = stet_pkg::SCORE_W;
    localparam int TW = stet_pkg::TAG_W;
    localparam int PW = stet_pkg::POS_W;

    // latched command
    logic [stet_pkg::MODE_W-1:0] r_mode;
    logic [NW-1:0]               r_name;
    logic [SW-1:0]               r_score_in;
    logic [TW-1:0]               r_tag;
    logic [PW-1:0]               r_pos;

    // entry cells
    logic [SW-1:0] r_score [ENTRIES];
    logic [NW-1:0] r_ename [ENTRIES];
    logic [TW-1:0] r_etag  [ENTRIES];

    logic [ENTRIES-1:0] r_gt;
    logic [ENTRIES-1:0] r_match;

    logic          r_ok;
    logic [NW-1:0] r_rname;
    logic [SW-1:0] r_rscore;

    logic [NW-1:0]      n_name;
    logic               v_live;
    logic [ENTRIES-1:0] v_pre;
    logic [ENTRIES-1:0] v_suf;
    logic [ENTRIES-1:0] v_dpos;
    logic [ENTRIES-1:0] v_del;
    logic               v_pos_ok;
    logic               v_empty;
    logic               v_any_match;
    logic               v_ins;
    logic               v_delp;
    logic               v_delm;
    logic               v_clr;
    logic               n_ok;
    logic [NW-1:0]      n_rname;
    logic [SW-1:0]      n_rscore;
    logic [SW-1:0]      v_up_score [ENTRIES];
    logic [NW-1:0]      v_up_name  [ENTRIES];
    logic [TW-1:0]      v_up_tag   [ENTRIES];
    logic [SW-1:0]      v_dn_score [ENTRIES];
    logic [NW-1:0]      v_dn_name  [ENTRIES];
    logic [TW-1:0]      v_dn_tag   [ENTRIES];

    // name cut at first zero byte and to NAME_CHARS characters
    always_comb begin
        n_name = '0;
        v_live = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (i_name_key[8*b +: 8] == 8'd0 || b >= NAME_CHARS) begin
                v_live = 1'b0;
            end
            if (v_live) begin
                n_name[8*b +: 8] = i_name_key[8*b +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_name     <= n_name;
            r_score_in <= i_score;
            r_tag      <= i_tag;
            r_pos      <= i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.find) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_gt[i]    <= (r_score_in > r_score[i]);
                r_match[i] <= (r_ename[i] == r_name) && (r_score[i] == r_score_in);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            v_pre[i] = 1'b0;
            v_suf[i] = 1'b0;
            for (int j = 0; j < ENTRIES; j++) begin
                if (j <= i) begin
                    v_pre[i] = v_pre[i] | r_gt[j];
                end
                if (j > i) begin
                    v_suf[i] = v_suf[i] | r_match[j];
                end
            end
            v_dpos[i] = ((9'(i) + 9'd1) >= {1'b0, r_pos});
        end
        v_any_match = |r_match;
        v_pos_ok    = (r_pos != '0) && (r_pos <= PW'(ENTRIES));
        v_empty     = (r_score[0] == '0);
        v_ins  = (r_mode == stet_pkg::MODE_INSERT) && v_pre[ENTRIES-1];
        v_delp = (r_mode == stet_pkg::MODE_DEL_POS) && v_pos_ok && !v_empty;
        v_delm = (r_mode == stet_pkg::MODE_DEL_MATCH) && !v_empty && v_any_match;
        v_clr  = (r_mode == stet_pkg::MODE_CLEAR);
        for (int i = 0; i < ENTRIES; i++) begin
            v_del[i] = v_delp ? v_dpos[i] : (v_delm && !v_suf[i]);
        end

        // neighbor values: up = from the cell above, dn = from the cell below
        v_up_score[0] = r_score_in;
        v_up_name[0]  = r_name;
        v_up_tag[0]   = r_tag;
        for (int i = 1; i < ENTRIES; i++) begin
            v_up_score[i] = v_pre[i-1] ? r_score[i-1] : r_score_in;
            v_up_name[i]  = v_pre[i-1] ? r_ename[i-1] : r_name;
            v_up_tag[i]   = v_pre[i-1] ? r_etag[i-1]  : r_tag;
        end
        for (int i = 0; i < ENTRIES - 1; i++) begin
            v_dn_score[i] = r_score[i+1];
            v_dn_name[i]  = r_ename[i+1];
            v_dn_tag[i]   = r_etag[i+1];
        end
        v_dn_score[ENTRIES-1] = '0;
        v_dn_name[ENTRIES-1]  = '0;
        v_dn_tag[ENTRIES-1]   = '0;

        n_rname  = '0;
        n_rscore = '0;
        n_ok     = 1'b0;
        case (r_mode)
            stet_pkg::MODE_INSERT:    n_ok = v_ins;
            stet_pkg::MODE_DEL_POS:   n_ok = v_delp;
            stet_pkg::MODE_DEL_MATCH: n_ok = v_delm;
            stet_pkg::MODE_CLEAR:     n_ok = 1'b1;
            stet_pkg::MODE_READ: begin
                n_ok = v_pos_ok;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_pos == PW'(i + 1)) begin
                        n_rname  = r_ename[i];
                        n_rscore = r_score[i];
                    end
                end
            end
            default: n_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_score[i] <= '0;
                r_ename[i] <= '0;
                r_etag[i]  <= '0;
            end
        end else if (i_cmd.apply) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (v_clr) begin
                    r_score[i] <= '0;
                    r_ename[i] <= '0;
                    r_etag[i]  <= '0;
                end else if (v_ins && v_pre[i]) begin
                    r_score[i] <= v_up_score[i];
                    r_ename[i] <= v_up_name[i];
                    r_etag[i]  <= v_up_tag[i];
                end else if (v_del[i]) begin
                    r_score[i] <= v_dn_score[i];
                    r_ename[i] <= v_dn_name[i];
                    r_etag[i]  <= v_dn_tag[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_ok     <= n_ok;
            r_rname  <= n_rname;
            r_rscore <= n_rscore;
        end
    end

    assign o_ok         = r_ok;
    assign o_read_name  = r_rname;
    assign o_read_score = r_rscore;
    assign o_is_empty   = (r_score[0] == '0);
    assign o_is_full    = (r_score[ENTRIES-1] != '0);
    assign o_last_score = r_score[ENTRIES-1];

    a_sorted_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_score[0] >= r_score[ENTRIES-1])
        else $error("table order broken");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && v_clr) |=> (r_score[0] == '0) && (r_score[ENTRIES-1] == '0))
        else $error("clear left entries");
    a_insert_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && v_ins) |=> (r_score[0] != '0))
        else $error("insert left table empty");

endmodule

`default_nettype wire

### rtl/sorted_top_entries_table_unit.sv
// Top level: stream ports, controller and entry datapath.
// Each input beat passes the load, compare and update states before its result beat.
// The state machine works on one item at a time and waits for the result beat to be
// taken before it accepts the next input beat.
// Reset (synchronous, active low) blanks every entry and returns to idle.
`default_nettype none

module sorted_top_entries_table_unit #(
    parameter int ENTRIES    = stet_pkg::ENTRIES_DEF,
    parameter int NAME_CHARS = stet_pkg::NAME_CHARS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // name_key[63:0], score[95:64], tag[127:96], position[135:128]
    input  wire  [stet_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // mode[2:0]
    input  wire  [stet_pkg::MODE_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // ok[0], read_name[64:1], read_score[96:65], is_empty[97], is_full[98],
    // last_score[130:99], zero[135:131]
    output logic [stet_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    stet_pkg::t_cmd                   cmd;
    logic                             ok;
    logic [stet_pkg::NAME_W-1:0]      read_name;
    logic [stet_pkg::SCORE_W-1:0]     read_score;
    logic                             is_empty;
    logic                             is_full;
    logic [stet_pkg::SCORE_W-1:0]     last_score;

    stet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    stet_datapath #(
        .ENTRIES    (ENTRIES),
        .NAME_CHARS (NAME_CHARS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (s_axis_tuser),
        .i_name_key   (s_axis_tdata[63:0]),
        .i_score      (s_axis_tdata[95:64]),
        .i_tag        (s_axis_tdata[127:96]),
        .i_position   (s_axis_tdata[135:128]),
        .o_ok         (ok),
        .o_read_name  (read_name),
        .o_read_score (read_score),
        .o_is_empty   (is_empty),
        .o_is_full    (is_full),
        .o_last_score (last_score)
    );

    assign m_axis_tdata = {5'd0, last_score, is_full, is_empty, read_score, read_name, ok};

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking stream testbench for the sorted top entries table.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH       = stet_pkg::ENTRIES_DEF;
    localparam int NAME_CHARS  = stet_pkg::NAME_CHARS_DEF;
    localparam int MODE_W      = stet_pkg::MODE_W;
    localparam int NAME_W      = stet_pkg::NAME_W;
    localparam int SCORE_W     = stet_pkg::SCORE_W;
    localparam int TAG_W       = stet_pkg::TAG_W;
    localparam int POS_W       = stet_pkg::POS_W;
    localparam int IN_DATA_W   = stet_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = stet_pkg::OUT_DATA_W;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 20;

    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = stet_pkg::MODE_READ + 1'b1;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = '1;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [NAME_W-1:0]       name;
        logic [SCORE_W-1:0]      score;
        logic signed [TAG_W-1:0] tag;
        logic [POS_W-1:0]        pos;
    } t_table_op;

    typedef struct packed {
        logic               ok;
        logic [NAME_W-1:0]  read_name;
        logic [SCORE_W-1:0] read_score;
        logic               is_empty;
        logic               is_full;
        logic [SCORE_W-1:0] last_score;
    } t_table_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [MODE_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [NAME_W-1:0]  tbl_name  [DEPTH];
    logic [SCORE_W-1:0] tbl_score [DEPTH];
    logic [TAG_W-1:0]   tbl_tag   [DEPTH];

    t_table_result pending_results[$];
    t_table_result want;
    t_table_result got;
    int            err_count = 0;
    int            result_count = 0;
    int            stall_cycles = 0;
    int            rx_hold_req = 0;

    sorted_top_entries_table_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [NAME_W-1:0] norm_key(input logic [NAME_W-1:0] k);
        logic [NAME_W-1:0] r;
        bit                stop;
        r = '0;
        stop = 1'b0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            if (k[8*i +: 8] == 8'h00) stop = 1'b1;
            if (!stop) r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    function automatic void drop_entry(input int idx);
        for (int i = idx; i + 1 < DEPTH; i++) begin
            tbl_name[i]  = tbl_name[i+1];
            tbl_score[i] = tbl_score[i+1];
            tbl_tag[i]   = tbl_tag[i+1];
        end
        tbl_name[DEPTH-1]  = '0;
        tbl_score[DEPTH-1] = '0;
        tbl_tag[DEPTH-1]   = '0;
    endfunction

    function automatic t_table_result step_score_table(input t_table_op op);
        t_table_result     r;
        logic [NAME_W-1:0] key;
        int                spot;
        int                hit;
        bit                pos_ok;
        r = '0;
        key = norm_key(op.name);
        pos_ok = (op.pos >= 1) && (op.pos <= DEPTH);
        case (op.mode)
            stet_pkg::MODE_INSERT: begin
                spot = 0;
                while (spot < DEPTH && op.score <= tbl_score[spot]) spot++;
                if (spot < DEPTH) begin
                    for (int i = DEPTH - 1; i > spot; i--) begin
                        tbl_name[i]  = tbl_name[i-1];
                        tbl_score[i] = tbl_score[i-1];
                        tbl_tag[i]   = tbl_tag[i-1];
                    end
                    tbl_name[spot]  = key;
                    tbl_score[spot] = op.score;
                    tbl_tag[spot]   = op.tag;
                    r.ok = 1'b1;
                end
            end
            stet_pkg::MODE_DEL_POS: begin
                if (pos_ok && tbl_score[0] != 0) begin
                    drop_entry(int'(op.pos) - 1);
                    r.ok = 1'b1;
                end
            end
            stet_pkg::MODE_DEL_MATCH: begin
                if (tbl_score[0] != 0) begin
                    hit = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (tbl_name[i] == key && tbl_score[i] == op.score) hit = i;
                    if (hit >= 0) begin
                        drop_entry(hit);
                        r.ok = 1'b1;
                    end
                end
            end
            stet_pkg::MODE_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) begin
                    tbl_name[i]  = '0;
                    tbl_score[i] = '0;
                    tbl_tag[i]   = '0;
                end
                r.ok = 1'b1;
            end
            stet_pkg::MODE_READ: begin
                if (pos_ok) begin
                    r.read_name  = tbl_name[int'(op.pos) - 1];
                    r.read_score = tbl_score[int'(op.pos) - 1];
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.is_empty   = (tbl_score[0] == 0);
        r.is_full    = (tbl_score[DEPTH-1] != 0);
        r.last_score = tbl_score[DEPTH-1];
        return r;
    endfunction

    function automatic t_table_op mk_op(input logic [MODE_W-1:0] mode,
                                        input logic [NAME_W-1:0] name,
                                        input logic [SCORE_W-1:0] score,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [POS_W-1:0] pos);
        t_table_op op;
        op.mode  = mode;
        op.name  = name;
        op.score = score;
        op.tag   = tag;
        op.pos   = pos;
        return op;
    endfunction

    // full random keys, short names, or short names with junk after the terminator
    function automatic logic [NAME_W-1:0] rand_name();
        logic [NAME_W-1:0] k;
        int                len;
        int                pick;
        pick = $urandom_range(0, 9);
        k = {$urandom, $urandom};
        if (pick >= 4) begin
            len = $urandom_range(1, 8);
            for (int b = 0; b < 8; b++) begin
                if (b < len) k[8*b +: 8] = 8'($urandom_range(8'h41, 8'h5A));
                else if (b == len || pick < 8) k[8*b +: 8] = 8'h00;
            end
        end
        return k;
    endfunction

    function automatic t_table_op pick_random_op();
        t_table_op op;
        int        pick;
        int        idx;
        int        len;
        op = mk_op(stet_pkg::MODE_READ, rand_name(), $urandom, $urandom, 8'($urandom));
        pick = $urandom_range(0, 99);
        idx = $urandom_range(0, DEPTH - 1);
        if (pick < 50) begin
            op.mode = stet_pkg::MODE_INSERT;
            case ($urandom_range(0, 19))
                0, 1:        op.score = '0;
                2, 3, 4:     op.score = tbl_score[idx];
                5, 6:        op.score = '1 - $urandom_range(0, 4);
                7, 8:        op.score = $urandom;
                default:     op.score = $urandom_range(1, 60);
            endcase
        end else if (pick < 62) begin
            op.mode = stet_pkg::MODE_DEL_POS;
            if ($urandom_range(0, 2) != 0) op.pos = POS_W'($urandom_range(1, DEPTH));
        end else if (pick < 74) begin
            op.mode = stet_pkg::MODE_DEL_MATCH;
            if ($urandom_range(0, 9) < 7) begin
                op.name = tbl_name[idx];
                op.score = tbl_score[idx];
                len = 0;
                while (len < 8 && op.name[8*len +: 8] != 8'h00) len++;
                if ($urandom_range(0, 1) != 0)
                    for (int b = len + 1; b < 8; b++) op.name[8*b +: 8] = 8'($urandom);
            end
        end else if (pick < 95) begin
            op.mode = stet_pkg::MODE_READ;
            if ($urandom_range(0, 4) != 0) op.pos = POS_W'($urandom_range(1, DEPTH));
        end else if (pick < 96) begin
            op.mode = stet_pkg::MODE_CLEAR;
        end else begin
            op.mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        end
        return op;
    endfunction

    task automatic send_op(input t_table_op op);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op.mode;
        s_axis_tdata  = {op.pos, op.tag, op.score, op.name};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(step_score_table(op));
    endtask

    task automatic tx_idle(input int n);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        tx_idle(1);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [NAME_W-1:0] got_v,
                                   input logic [NAME_W-1:0] want_v);
        $display("%0t: beat %0d %s got %h want %h", $time, result_count, what,
                 got_v, want_v);
        err_count++;
    endtask

    task automatic test_directed();
        send_op(mk_op(stet_pkg::MODE_READ, '0, '0, '0, 8'd1));
        send_op(mk_op(stet_pkg::MODE_DEL_POS, '0, '0, '0, 8'd1));
        send_op(mk_op(stet_pkg::MODE_DEL_MATCH, '0, '0, '0, '0));
        send_op(mk_op(stet_pkg::MODE_INSERT, 64'h0000_0045_4349_4C41, '0, 32'h1234_5678,
                      '0));
        send_op(mk_op(stet_pkg::MODE_INSERT, 64'h0000_0045_4349_4C41, '1, 32'h7FFF_FFFF,
                      '0));
        send_op(mk_op(stet_pkg::MODE_INSERT, 64'hA5C3_0000_4445_4647, 32'd100,
                      32'h8000_0000, '1));
        send_op(mk_op(stet_pkg::MODE_INSERT, '1, 32'd100, '1, '0));
        send_op(mk_op(stet_pkg::MODE_INSERT, '0, 32'd1, '0, '0));
        send_op(mk_op(stet_pkg::MODE_READ, '1, '1, '1, 8'd0));
        send_op(mk_op(stet_pkg::MODE_READ, '0, '0, '0, 8'(DEPTH + 1)));
        send_op(mk_op(stet_pkg::MODE_READ, '0, '0, '0, '1));
        send_op(mk_op(stet_pkg::MODE_READ, '0, '0, '0, 8'(DEPTH)));
        send_op(mk_op(stet_pkg::MODE_READ, '0, '0, '0, 8'd2));
        send_op(mk_op(stet_pkg::MODE_READ, '0, '0, '0, 8'd3));
        // same key once cut at its first zero byte
        send_op(mk_op(stet_pkg::MODE_DEL_MATCH, 64'h1234_5600_4445_4647, 32'd100, '0, '0));
        send_op(mk_op(stet_pkg::MODE_DEL_POS, '0, '0, '0, 8'(DEPTH)));
        send_op(mk_op(stet_pkg::MODE_DEL_MATCH, '0, '0, '0, '0));
        send_op(mk_op(stet_pkg::MODE_DEL_POS, '0, '0, '0, 8'd0));
        send_op(mk_op(stet_pkg::MODE_DEL_POS, '0, '0, '0, 8'(DEPTH + 1)));
        for (int m = MODE_UNUSED_FIRST; m <= int'(MODE_UNUSED_LAST); m++)
            send_op(mk_op(3'(m), rand_name(), $urandom, $urandom, 8'd1));
        send_op(mk_op(stet_pkg::MODE_CLEAR, rand_name(), $urandom, $urandom,
                      POS_W'($urandom)));
        send_op(mk_op(stet_pkg::MODE_READ, '0, '0, '0, 8'd1));
        send_op(mk_op(stet_pkg::MODE_INSERT, rand_name(), 32'd1, 32'h8000_0000, '0));
    endtask

    task automatic test_full_table();
        logic [NAME_W-1:0] nm;
        send_op(mk_op(stet_pkg::MODE_CLEAR, '0, '0, '0, '0));
        for (int i = 0; i < DEPTH; i++) begin
            if (i % 2 == 0) nm = rand_name();
            send_op(mk_op(stet_pkg::MODE_INSERT, nm, 32'd2000 - 32'(100 * (i / 2)),
                          $urandom, '0));
        end
        send_op(mk_op(stet_pkg::MODE_INSERT, rand_name(), 32'd5, '0, '0));
        send_op(mk_op(stet_pkg::MODE_INSERT, rand_name(), tbl_score[DEPTH-1], '0, '0));
        send_op(mk_op(stet_pkg::MODE_INSERT, rand_name(), tbl_score[DEPTH-1] + 1, '0, '0));
        send_op(mk_op(stet_pkg::MODE_INSERT, rand_name(), '1, '1, '0));
        send_op(mk_op(stet_pkg::MODE_DEL_MATCH, tbl_name[3], tbl_score[3], '0, '0));
        send_op(mk_op(stet_pkg::MODE_READ, '0, '0, '0, 8'(DEPTH)));
        send_op(mk_op(stet_pkg::MODE_DEL_POS, '0, '0, '0, 8'd1));
        send_op(mk_op(stet_pkg::MODE_READ, '0, '0, '0, 8'd1));
    endtask

    task automatic test_random_traffic(input int n_ops);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_ops) begin
            burst = $urandom_range(1, 32);
            for (int i = 0; i < burst && sent < n_ops; i++) begin
                send_op(pick_random_op());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) tx_idle($urandom_range(1, 10));
        end
    endtask

    task automatic test_output_holdoff();
        rx_hold_req = HOLD_CYCLES;
        for (int i = 0; i < 24; i++) send_op(pick_random_op());
        wait_results_drained();
    endtask

    task automatic test_pause_until_drained();
        for (int i = 0; i < 12; i++) send_op(pick_random_op());
        wait_results_drained();
        for (int i = 0; i < 12; i++) send_op(pick_random_op());
    endtask

    // receiver: long hold-off on request, otherwise a changing stall pattern
    initial begin
        int hold_left;
        int style;
        int style_left;
        hold_left = 0;
        style = 0;
        style_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                if (style_left == 0) begin
                    style = $urandom_range(0, 3);
                    style_left = $urandom_range(16, 200);
                end
                style_left--;
                case (style)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = ($urandom_range(0, 3) != 0);
                    2: m_axis_tready = ($urandom_range(0, 1) != 0);
                    default: m_axis_tready = (style_left % 5 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ok         = m_axis_tdata[0];
            got.read_name  = m_axis_tdata[64:1];
            got.read_score = m_axis_tdata[96:65];
            got.is_empty   = m_axis_tdata[97];
            got.is_full    = m_axis_tdata[98];
            got.last_score = m_axis_tdata[130:99];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata[63:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", NAME_W'(got.ok), NAME_W'(want.ok));
                if (got.read_name !== want.read_name)
                    report_mismatch("read_name", got.read_name, want.read_name);
                if (got.read_score !== want.read_score)
                    report_mismatch("read_score", NAME_W'(got.read_score),
                                    NAME_W'(want.read_score));
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", NAME_W'(got.is_empty),
                                    NAME_W'(want.is_empty));
                if (got.is_full !== want.is_full)
                    report_mismatch("is_full", NAME_W'(got.is_full),
                                    NAME_W'(want.is_full));
                if (got.last_score !== want.last_score)
                    report_mismatch("last_score", NAME_W'(got.last_score),
                                    NAME_W'(want.last_score));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            tbl_name[i]  = '0;
            tbl_score[i] = '0;
            tbl_tag[i]   = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_table();
        test_random_traffic(900);
        test_output_holdoff();
        test_pause_until_drained();
        test_random_traffic(800);

        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
